@@ sv/pwl_pkg.sv @@
package pwl_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = 7;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_QUERY   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_RD_NXT,
        S_SCAN,
        S_SEG0,
        S_SEG1,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    // Request handed from the sequencer to the shared multiply/divide unit.
    typedef struct packed {
        logic        start;
        logic [31:0] dx_mag;
        logic [31:0] dv_mag;
        logic [31:0] dt_mag;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic        zero_prod;
    } t_md_rsp;

endpackage

@@ sv/pwl_muldiv.sv @@
module pwl_muldiv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pwl_pkg::t_md_req i_req,
    output pwl_pkg::t_md_rsp o_rsp
);

    // Multiply is shift-add one bit per cycle; divide is restoring, one bit per cycle.
    logic [31:0] r_mcand, n_mcand;
    logic [31:0] r_mplier, n_mplier;
    logic [63:0] r_prod, n_prod;
    logic [31:0] r_div, n_div;
    logic [32:0] r_rem, n_rem;
    logic [63:0] r_quot, n_quot;
    logic [6:0]  r_cnt, n_cnt;
    logic [1:0]  r_ph, n_ph;
    logic [32:0] w_trial;
    logic        w_done;

    localparam logic [1:0] PhIdle = 2'd0, PhMul = 2'd1, PhDiv = 2'd2;

    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_prod   = r_prod;
        n_div    = r_div;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_cnt    = r_cnt;
        n_ph     = r_ph;
        w_done   = 1'b0;
        w_trial  = {r_rem[31:0], r_quot[63]} - {1'b0, r_div};
        unique case (r_ph)
            PhIdle: begin
                if (i_req.start) begin
                    n_mcand  = i_req.dx_mag;
                    n_mplier = i_req.dv_mag;
                    n_div    = i_req.dt_mag;
                    n_prod   = '0;
                    n_cnt    = 7'd0;
                    n_ph     = PhMul;
                end
            end
            PhMul: begin
                n_prod = r_mplier[31] ? ({r_prod[62:0], 1'b0} + {32'd0, r_mcand})
                                      : {r_prod[62:0], 1'b0};
                n_mplier = {r_mplier[30:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    n_cnt  = 7'd0;
                    n_ph   = PhDiv;
                    n_rem  = '0;
                    n_quot = r_mplier[31] ? ({r_prod[62:0], 1'b0} + {32'd0, r_mcand})
                                          : {r_prod[62:0], 1'b0};
                end
            end
            PhDiv: begin
                if (!w_trial[32]) begin
                    n_rem  = w_trial;
                    n_quot = {r_quot[62:0], 1'b1};
                end else begin
                    n_rem  = {r_rem[31:0], r_quot[63]};
                    n_quot = {r_quot[62:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_ph   = PhIdle;
                    w_done = 1'b1;
                end
            end
            default: n_ph = PhIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PhIdle;
            r_cnt <= '0;
        end else begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
    end

    logic r_done;
    logic r_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= w_done;
        if (r_ph == PhMul && r_cnt == 7'd31) r_zero <= (n_quot == 64'd0);
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quot      = r_quot;
    assign o_rsp.zero_prod = r_zero;

endmodule

@@ sv/pwl_interpolator_forward_cursor.sv @@
// Piecewise-linear waveform evaluator with a cursor that only moves forward.
//
// Input channel: i_valid / o_stall with fields operation, point_index,
// point_time, point_value and query_time. An item is taken at a clock edge
// where i_valid is high and o_stall is low. A load writes one table entry and
// a restart puts the cursor back to segment zero; neither produces a result.
// Code 3 is dropped. A query produces one result on o_valid / i_stall.
// Configuration: i_cfg_valid / o_cfg_ready write point_count (7 bits). The
// port is ready whenever the block is idle.
//
// Sequence: load and restart are done as they are taken. A query reads one table entry per
// cycle, and each segment the cursor passes costs an S_RD_NXT and an S_SCAN state. The
// shared serial unit then runs the multiply and the division before S_DONE writes the
// result; the next item can be taken in the cycle that shows the result, unless the
// receiver stalls. Held and zero-width queries skip the multiply and the division, and
// a single point goes from S_RD_CUR straight to S_DONE. One item is in work at a time.
//
// Reset (synchronous, active low) clears the cursor, sets point_count to 1 and
// empties the output register. The tables are not cleared. When the receiver
// stalls, the result stays in the output register and no new item is taken.
module pwl_interpolator_forward_cursor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_point_index,
    input  logic signed [31:0] i_point_time,
    input  logic signed [31:0] i_point_value,
    input  logic signed [31:0] i_query_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_point_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_interp_value,
    output logic [5:0]  o_segment_index,
    output logic        o_held_at_end
);

    localparam int IW = pwl_pkg::IdxW;

    pwl_pkg::t_state r_state, n_state;

    // Tables: one combined memory, one write and one registered read per cycle.
    logic [63:0] r_mem [pwl_pkg::MaxPoints];
    logic [63:0] r_rd;
    logic [IW-1:0] w_rd_addr;
    logic          w_wr_en;

    logic [6:0]    r_cnt_cfg;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [IW-1:0] r_last;             // n-1
    logic [IW-1:0] r_i, n_i;           // scan index
    logic signed [31:0] r_q;
    logic signed [31:0] r_t0, r_v0, r_t1, r_v1;
    logic        r_neg;
    logic        r_out_v;
    logic signed [31:0] r_out_y;
    logic [IW-1:0] r_out_seg;
    logic        r_out_held;

    logic        w_accept;
    logic        w_busy;
    pwl_pkg::t_md_req w_req;
    pwl_pkg::t_md_rsp w_rsp;

    logic signed [32:0] w_dt, w_dx, w_dv;
    logic signed [36:0] w_sum;
    logic [6:0]  w_n;
    logic        w_emit;
    logic signed [31:0] w_y;
    logic        w_held;

    assign w_busy   = (r_state != pwl_pkg::S_IDLE);
    assign o_stall  = w_busy || (r_out_v && i_stall);
    assign o_cfg_ready = !w_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_wr_en  = w_accept && (pwl_pkg::t_op'(i_operation) == pwl_pkg::OP_LOAD);

    // Effective point count: zero reads as one, above the table is clamped.
    always_comb begin
        if (r_cnt_cfg == 7'd0) w_n = 7'd1;
        else if (r_cnt_cfg > 7'(pwl_pkg::MaxPoints)) w_n = 7'(pwl_pkg::MaxPoints);
        else w_n = r_cnt_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[i_point_index] <= {i_point_time, i_point_value};
        r_rd <= r_mem[w_rd_addr];
    end

    assign w_dt = {r_t1[31], r_t1} - {r_t0[31], r_t0};
    assign w_dx = {r_q[31], r_q} - {r_t0[31], r_t0};
    assign w_dv = {r_v1[31], r_v1} - {r_v0[31], r_v0};

    // Both segment ends are in registers by S_MUL, so the request starts there.
    always_comb begin
        w_req.start  = 1'b0;
        w_req.dx_mag = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
        w_req.dv_mag = w_dv[32] ? 32'(-w_dv) : w_dv[31:0];
        w_req.dt_mag = w_dt[32] ? 32'(-w_dt) : w_dt[31:0];
        if (r_state == pwl_pkg::S_MUL && !(r_cursor == r_last) && w_dt != 33'sd0)
            w_req.start = 1'b1;
    end

    pwl_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // The quotient reaches this sum only up to 2^34, so 35 of its bits suffice.
    assign w_sum = r_neg ? ({{5{r_v0[31]}}, r_v0} - $signed({2'b0, w_rsp.quot[34:0]}))
                         : ({{5{r_v0[31]}}, r_v0} + $signed({2'b0, w_rsp.quot[34:0]}));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pwl_pkg::S_IDLE:
                if (w_accept && pwl_pkg::t_op'(i_operation) == pwl_pkg::OP_QUERY)
                    n_state = (w_n == 7'd1) ? pwl_pkg::S_RD_CUR : pwl_pkg::S_RD_NXT;
            pwl_pkg::S_RD_CUR: n_state = pwl_pkg::S_DONE;
            pwl_pkg::S_RD_NXT: n_state = pwl_pkg::S_SCAN;
            pwl_pkg::S_SCAN: begin
                if (r_i == r_last || $signed(r_rd[63:32]) >= r_q) n_state = pwl_pkg::S_SEG0;
                else n_state = pwl_pkg::S_RD_NXT;
            end
            pwl_pkg::S_SEG0: n_state = pwl_pkg::S_SEG1;
            pwl_pkg::S_SEG1: n_state = pwl_pkg::S_MUL;
            pwl_pkg::S_MUL:  n_state = w_req.start ? pwl_pkg::S_DIV : pwl_pkg::S_DONE;
            pwl_pkg::S_DIV:  if (w_rsp.done) n_state = pwl_pkg::S_DONE;
            pwl_pkg::S_DONE: n_state = pwl_pkg::S_IDLE;
            default:         n_state = pwl_pkg::S_IDLE;
        endcase
    end

    // Read address, cursor and scan index.
    always_comb begin
        w_rd_addr = r_cursor;
        n_cursor  = r_cursor;
        n_i       = r_i;
        w_emit    = 1'b0;
        w_y       = r_v0;
        w_held    = 1'b0;
        unique case (r_state)
            pwl_pkg::S_IDLE: begin
                if (w_accept && pwl_pkg::t_op'(i_operation) == pwl_pkg::OP_RESTART)
                    n_cursor = '0;
                if (w_accept && pwl_pkg::t_op'(i_operation) == pwl_pkg::OP_QUERY) begin
                    if (w_n == 7'd1) begin
                        n_cursor = '0;
                        w_rd_addr = '0;
                    end else begin
                        if ({1'b0, r_cursor} > (w_n - 7'd1))
                            n_cursor = IW'(w_n - 7'd1);
                        n_i = n_cursor;
                        w_rd_addr = (n_cursor == IW'(w_n - 7'd1)) ? n_cursor : n_cursor + 1'b1;
                    end
                end
            end
            pwl_pkg::S_RD_CUR: begin
                w_rd_addr = r_cursor;
            end
            pwl_pkg::S_RD_NXT: begin
                w_rd_addr = (r_i == r_last) ? r_i : r_i + 1'b1;
            end
            pwl_pkg::S_SCAN: begin
                // r_rd is entry r_i+1 (or r_i when at the last point).
                if (r_i == r_last) begin
                    w_rd_addr = r_i;
                end else if ($signed(r_rd[63:32]) >= r_q) begin
                    n_cursor = r_i;
                    w_rd_addr = r_i + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                    if (n_i == r_last) n_cursor = r_last;
                    w_rd_addr = (n_i == r_last) ? n_i : n_i + 1'b1;
                end
            end
            pwl_pkg::S_SEG0: w_rd_addr = r_cursor;
            pwl_pkg::S_SEG1: w_rd_addr = r_cursor;
            pwl_pkg::S_DONE: begin
                w_emit = 1'b1;
                if (r_cursor == r_last) begin
                    w_y = r_v0;
                    w_held = 1'b1;
                end else if (w_dt == 33'sd0 || w_rsp.zero_prod) begin
                    w_y = r_v0;
                end else if (w_rsp.quot > 64'h4_0000_0000) begin
                    w_y = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else if (w_sum > 37'sh7FFF_FFFF) begin
                    w_y = 32'sh7FFF_FFFF;
                end else if (w_sum < -37'sh8000_0000) begin
                    w_y = 32'sh8000_0000;
                end else begin
                    w_y = w_sum[31:0];
                end
            end
            default: ;
        endcase
    end

    // Scan bookkeeping. S_RD_NXT repeats the address of entry r_i+1, so r_rd
    // holds that entry in S_SCAN. S_SEG0 sees the right end of the segment and
    // S_SEG1 its left end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pwl_pkg::S_IDLE;
            r_cursor  <= '0;
            r_cnt_cfg <= 7'd1;
            r_out_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            if (i_cfg_valid && o_cfg_ready) r_cnt_cfg <= i_point_count;
            if (w_emit) r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
        end
        r_i <= n_i;
        if (w_accept) begin
            r_q    <= i_query_time;
            r_last <= IW'(w_n - 7'd1);
        end
        if (r_state == pwl_pkg::S_SEG0) begin
            r_t1 <= r_rd[63:32];
            r_v1 <= r_rd[31:0];
        end
        if (r_state == pwl_pkg::S_RD_CUR)
            r_v0 <= r_rd[31:0];
        if (r_state == pwl_pkg::S_SEG1) begin
            r_v0 <= r_rd[31:0];
            r_t0 <= r_rd[63:32];
        end
        if (r_state == pwl_pkg::S_MUL)
            r_neg <= (w_dx[32] ^ w_dv[32]) ^ w_dt[32];
        if (w_emit) begin
            r_out_y    <= w_y;
            r_out_seg  <= r_cursor;
            r_out_held <= w_held;
        end
    end

    assign o_valid         = r_out_v;
    assign o_interp_value  = r_out_y;
    assign o_segment_index = 6'(r_out_seg);
    assign o_held_at_end   = r_out_held;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_accept) else $error("item taken while busy");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwl_pkg::S_DONE) |-> ({1'b0, r_cursor} <= w_n - 7'd1))
        else $error("cursor past last point");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_interp_value)))
        else $error("stalled result changed");

endmodule

@@ test/pwl_interpolator_forward_cursor_test.sv @@
module pwl_interpolator_forward_cursor_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The clock runs at 2 ns. Reset is held low at the start and is
    // never asserted again.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Every block input starts at a known value.
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_operation = pwl_pkg::OP_NONE;
    logic [5:0]         i_point_index = '0;
    logic signed [31:0] i_point_time = '0;
    logic signed [31:0] i_point_value = '0;
    logic signed [31:0] i_query_time = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [6:0]         i_point_count = 7'd1;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_interp_value;
    logic [5:0]         o_segment_index;
    logic               o_held_at_end;

    pwl_interpolator_forward_cursor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_point_index  (i_point_index),
        .i_point_time   (i_point_time),
        .i_point_value  (i_point_value),
        .i_query_time   (i_query_time),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_point_count  (i_point_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_interp_value (o_interp_value),
        .o_segment_index(o_segment_index),
        .o_held_at_end  (o_held_at_end)
    );

    // One waveform sample as the block reports it.
    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         segment;
        logic               held;
    } t_sample;

    // The testbench's own copy of the block state. Times and values are kept
    // sign-extended so that differences never wrap.
    longint      bp_time [pwl_pkg::MaxPoints];
    longint      bp_value[pwl_pkg::MaxPoints];
    int unsigned cursor_pos = 0;
    int unsigned count_reg  = 1;

    t_sample awaited_samples[$];
    int      fail_count    = 0;
    int      checked_count = 0;
    int      item_count    = 0;
    int      query_count   = 0;
    int      setting_count = 0;

    // A directed item may carry a result typed in by hand. These travel with
    // the item, so the capture process sees them at the edge it is taken.
    logic               pin_on = 1'b0;
    logic signed [31:0] pin_value = '0;
    logic [5:0]         pin_segment = '0;
    logic               pin_held = 1'b0;

    // Side controls: a calm stretch turns off random idling on both sides,
    // and a hold request makes the receiver stall for a long stretch.
    bit calm = 1'b0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    function automatic longint sat_q16(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Linear step from v0: v0 + trunc(dx * dv / dt), with the product kept
    // exact in 64 bits and the sum saturated to 32 bits. Quotients far out of
    // range go straight to the rail of their sign.
    function automatic longint slope_step(longint v0, longint dx, longint dv, longint dt);
        longint unsigned prod;
        longint unsigned quo;
        bit              neg;
        prod = magnitude(dx) * magnitude(dv);
        quo  = prod / magnitude(dt);
        neg  = ((dx < 0) != (dv < 0)) != (dt < 0);
        if (prod == 0)
            return sat_q16(v0);
        if (quo > (64'd1 << 34))
            return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        return sat_q16(neg ? v0 - longint'(quo) : v0 + longint'(quo));
    endfunction

    // Moves the cursor for one query and works out the sample it yields.
    function automatic t_sample waveform_sample(logic signed [31:0] query);
        int unsigned n;
        int unsigned c;
        longint      q;
        longint      y;
        longint      dt;
        bit          held;
        bit          found;
        t_sample     s;
        n = (count_reg == 0) ? 1 : ((count_reg > pwl_pkg::MaxPoints) ? pwl_pkg::MaxPoints
                                                                      : count_reg);
        // A lowered point count pulls a cursor that sits past it back in.
        if (cursor_pos > n - 1)
            cursor_pos = n - 1;
        q    = query;
        held = 1'b0;
        if (n == 1) begin
            cursor_pos = 0;
            y          = bp_value[0];
            held       = 1'b1;
        end else begin
            c = cursor_pos;
            if (c < n - 1 && q > bp_time[c + 1]) begin
                found = 1'b0;
                for (int unsigned i = c + 1; i + 1 < n; i++) begin
                    if (!found && q <= bp_time[i + 1]) begin
                        cursor_pos = i;
                        found      = 1'b1;
                    end
                end
                if (!found && q > bp_time[n - 1])
                    cursor_pos = n - 1;
            end
            c = cursor_pos;
            if (c == n - 1) begin
                y    = bp_value[n - 1];
                held = 1'b1;
            end else begin
                dt = bp_time[c + 1] - bp_time[c];
                // A zero-width segment gives its left value.
                if (dt == 0)
                    y = bp_value[c];
                else
                    y = slope_step(bp_value[c], q - bp_time[c],
                                   bp_value[c + 1] - bp_value[c], dt);
            end
        end
        s.value   = y[31:0];
        s.segment = cursor_pos[5:0];
        s.held    = held;
        return s;
    endfunction

    // Capture side: every item taken by the block updates the state copy, and
    // each query adds one awaited sample.
    always @(posedge i_clk) begin : capture
        t_sample s;
        if (i_rst_n && i_valid && !o_stall) begin
            case (pwl_pkg::t_op'(i_operation))
                pwl_pkg::OP_LOAD: begin
                    bp_time[i_point_index]  = i_point_time;
                    bp_value[i_point_index] = i_point_value;
                end
                pwl_pkg::OP_RESTART: cursor_pos = 0;
                pwl_pkg::OP_QUERY: begin
                    s = waveform_sample(i_query_time);
                    if (pin_on) begin
                        s.value   = pin_value;
                        s.segment = pin_segment;
                        s.held    = pin_held;
                    end
                    awaited_samples.push_back(s);
                    query_count++;
                end
                default: ;
            endcase
        end
    end

    // Result side: each result taken from the block is held against the
    // oldest awaited sample, field by field.
    always @(posedge i_clk) begin : compare
        t_sample s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_samples.size() == 0) begin
                $error("result with nothing awaited: value %h segment %0d held %0d",
                       o_interp_value, o_segment_index, o_held_at_end);
                fail_count++;
            end else begin
                s = awaited_samples.pop_front();
                checked_count++;
                if (o_interp_value !== s.value) begin
                    $error("interp_value: expected %h, got %h", s.value, o_interp_value);
                    fail_count++;
                end
                if (o_segment_index !== s.segment) begin
                    $error("segment_index: expected %0d, got %0d", s.segment,
                           o_segment_index);
                    fail_count++;
                end
                if (o_held_at_end !== s.held) begin
                    $error("held_at_end: expected %0d, got %0d", s.held, o_held_at_end);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: stalls at random with a chance of 18 in a hundred, not at all
    // while calm, and without a break through a hold once one is asked for. During a hold the
    // sender keeps offering, so the result register fills and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_asked != hold_taken) begin
            hold_taken <= hold_asked;
            hold_left  <= 400;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    // Offers one item and waits until the block takes it. The valid stays up
    // when the next item follows at once, and drops for a short random gap
    // otherwise.
    task automatic offer(input pwl_pkg::t_op op, input logic [5:0] idx,
                         input logic [31:0] pt, input logic [31:0] pv,
                         input logic [31:0] qt,
                         input bit pinned = 1'b0, input t_sample pinned_s = '{0, 0, 0});
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_point_index <= idx;
        i_point_time  <= pt;
        i_point_value <= pv;
        i_query_time  <= qt;
        pin_on        <= pinned;
        pin_value     <= pinned_s.value;
        pin_segment   <= pinned_s.segment;
        pin_held      <= pinned_s.held;
        do
            @(posedge i_clk);
        while (o_stall);
        if (op != pwl_pkg::OP_NONE)
            item_count++;
        if (!calm && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Writes point_count once the block is idle. A load gives no result and
    // finishes as it is taken, so waiting past the last result covers it.
    task automatic write_count(input logic [6:0] cnt);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_samples.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_point_count <= cnt;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        count_reg = cnt;
        setting_count++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed rows. A row is either a point_count write or one item; where
    // the result is obvious it is typed in, otherwise the predictor decides.
    typedef struct {
        bit           is_cfg;
        logic [6:0]   cnt;
        pwl_pkg::t_op op;
        logic [5:0]   idx;
        logic [31:0]  pt;
        logic [31:0]  pv;
        logic [31:0]  qt;
        bit           pinned;
        t_sample      want;
    } t_plan_row;

    t_plan_row plan[0:24] = '{
        // Single breakpoint: the output is entry zero, held, for any time.
        '{0, 0, pwl_pkg::OP_LOAD,    0, 32'h0000_0000, 32'h0005_0000, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0000_0000, 1, '{32'h0005_0000, 0, 1}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h8000_0000, 1, '{32'h0005_0000, 0, 1}},
        // Four points with a zero-width step between entries one and two and
        // a drop from the top rail to the bottom rail after it.
        '{0, 0, pwl_pkg::OP_LOAD,    1, 32'h0001_0000, 32'h0001_0000, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_LOAD,    2, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_LOAD,    3, 32'h0002_0000, 32'h8000_0000, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_LOAD,    0, 32'h0000_0000, 32'h0000_0000, 0, 0, '{0, 0, 0}},
        '{1, 4, pwl_pkg::OP_NONE,    0, 0, 0, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0000_8000, 1, '{32'h0000_8000, 0, 0}},
        // Below the first segment the line is extended, down to the most
        // negative time.
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'hFFFF_0000, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h8000_0000, 0, '{0, 0, 0}},
        // The cursor skips the zero-width segment.
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0001_8000, 0, '{0, 0, 0}},
        // Past the end the last value holds.
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h7FFF_FFFF, 1, '{32'h8000_0000, 3, 1}},
        // Lowering the count below the cursor clamps it onto the last point.
        '{1, 2, pwl_pkg::OP_NONE,    0, 0, 0, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0000_0000, 1, '{32'h0001_0000, 1, 1}},
        // A count of zero acts as one.
        '{1, 0, pwl_pkg::OP_NONE,    0, 0, 0, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0000_0005, 1, '{32'h0000_0000, 0, 1}},
        '{1, 4, pwl_pkg::OP_NONE,    0, 0, 0, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_RESTART, 0, 0, 0, 0, 0, '{0, 0, 0}},
        // Zero-width first segment: its left value comes out.
        '{0, 0, pwl_pkg::OP_LOAD,    0, 32'h0001_0000, 32'h0003_0000, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h0000_0000, 1, '{32'h0003_0000, 0, 0}},
        // A steep segment extended far below saturates at the bottom rail.
        '{0, 0, pwl_pkg::OP_LOAD,    0, 32'h0000_0000, 32'h8000_0000, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_LOAD,    1, 32'h0000_0001, 32'h7FFF_FFFF, 0, 0, '{0, 0, 0}},
        '{0, 0, pwl_pkg::OP_QUERY,   0, 0, 0, 32'h8000_0000, 1, '{32'h8000_0000, 0, 0}},
        // The unused operation code is dropped without a result.
        '{0, 0, pwl_pkg::OP_NONE,    0, 0, 0, 0, 0, '{0, 0, 0}}
    };

    // Picks a query time near breakpoint w, clamped into 32 bits.
    function automatic logic [31:0] near_point(int unsigned w);
        longint q;
        q = bp_time[w] + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
        return 32'(sat_q16(q));
    endfunction

    initial begin : stimulus
        int unsigned settings[$] = '{64, 2, 1, 0, 127, 33, 64, 5, 64, 17, 100};
        int unsigned n;
        int unsigned walk;
        int unsigned roll;
        longint      t;
        int          per_setting;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg)
                write_count(plan[r].cnt);
            else
                offer(plan[r].op, plan[r].idx, plan[r].pt, plan[r].pv, plan[r].qt,
                      plan[r].pinned, plan[r].want);
        end

        // Fill the whole table with ascending times, some steps of zero width,
        // so every query below reads only written entries.
        t = longint'($urandom_range(0, 1 << 20)) - (1 << 26);
        for (int i = 0; i < pwl_pkg::MaxPoints; i++) begin
            offer(pwl_pkg::OP_LOAD, 6'(i), t[31:0], $urandom(), 32'd0);
            if ($urandom_range(9) != 0)
                t += $urandom_range(1, 1 << 20);
        end

        // The table fill and the directed rows account for about a hundred
        // items, so the random part brings the run to about 750.
        per_setting = 650 / settings.size();
        foreach (settings[k]) begin
            write_count(7'(settings[k]));
            n = (settings[k] == 0) ? 1 : ((settings[k] > pwl_pkg::MaxPoints) ?
                                          pwl_pkg::MaxPoints : settings[k]);
            if (k == 6)
                hold_asked++;
            calm = (k == 8);
            offer(pwl_pkg::OP_RESTART, 6'd0, 32'd0, 32'd0, 32'd0);
            walk = 0;
            for (int j = 0; j < per_setting; j++) begin
                roll = $urandom_range(99);
                if (roll < 6) begin
                    // Noise: overwrite an entry, with a random time half the
                    // time and otherwise keeping its place in the order.
                    walk = $urandom_range(0, pwl_pkg::MaxPoints - 1);
                    offer(pwl_pkg::OP_LOAD, walk[5:0],
                          $urandom_range(1) ? $urandom() : bp_time[walk][31:0],
                          $urandom(), $urandom());
                    walk = 0;
                end else if (roll < 9) begin
                    offer(pwl_pkg::OP_NONE, 6'($urandom()), $urandom(), $urandom(),
                          $urandom());
                end else if (roll < 14) begin
                    offer(pwl_pkg::OP_RESTART, 6'($urandom()), $urandom(), $urandom(),
                          $urandom());
                    walk = 0;
                end else if (roll < 22) begin
                    offer(pwl_pkg::OP_QUERY, 6'($urandom()), $urandom(), $urandom(),
                          $urandom());
                end else if (roll < 26) begin
                    offer(pwl_pkg::OP_QUERY, 6'd0, 32'd0, 32'd0,
                          $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
                end else begin
                    // Well-formed sweep: query times move forward along the
                    // table, now and then past the last point.
                    walk += $urandom_range(0, 2);
                    if (walk > n - 1)
                        walk = n - 1;
                    offer(pwl_pkg::OP_QUERY, 6'($urandom()), $urandom(), $urandom(),
                          near_point(walk));
                end
            end
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_samples.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Run covered %0d items, %0d queries and %0d checked results over %0d",
                 item_count, query_count, checked_count, setting_count);
        $display("point_count settings, with a long receiver hold and a calm stretch.");
        if (fail_count == 0 && awaited_samples.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // A query runs through the serial multiply and division plus a scan of the skipped
    // segments; 750 items with stalls fit well inside this bound.
    initial begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
sv/pwl_pkg.sv
sv/pwl_muldiv.sv
sv/pwl_interpolator_forward_cursor.sv
test/pwl_interpolator_forward_cursor_test.sv
